FILE: rtl/core/tfl_pkg.sv
// Shared constants, types and helpers for the text line folder.
package tfl_pkg;

   localparam int BUF_DEPTH_DEFAULT = 64;

   localparam int CHAR_W    = 8;
   localparam int FOLD_W    = 6;
   localparam int TAB_W     = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 6;

   localparam logic [CHAR_W-1:0] CH_NUL     = 8'd0;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

   localparam logic [FOLD_W-1:0] FOLD_WIDTH_RESET = 6'd20;
   localparam logic [TAB_W-1:0]  TAB_WIDTH_RESET  = 5'd8;
   localparam logic [TAB_W-1:0]  TAB_WIDTH_MAX    = 5'd16;

   localparam logic [CSR_IDX_W-1:0] REG_FOLD_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TAB_WIDTH  = 2'd1;

   // Per-cycle control that every cell of the character row sees.
   typedef struct packed {
      logic              shift;
      logic              load;
      logic [CHAR_W-1:0] load_char;
   } row_ctrl_type;

   function automatic logic is_blank(input logic [CHAR_W-1:0] c);
      is_blank = (c == CH_SPACE) || (c == CH_TAB);
   endfunction

endpackage

FILE: rtl/core/text_line_folder.sv
// Top level of the text line folder: control sequencer, settings and result register.
// Input channel (req_): one transfer carries a byte req_ch and the req_end_of_text
//   flag. A newline emits the pending line and a newline; end of text emits the
//   pending line without one. Other characters join the line, folding at the last
//   word boundary (or hard-breaking) when it would exceed fold_width columns or the
//   row is full; a tab counts tab_width columns, clamped to 1..16.
// Result channel (rsp_): one transfer per output byte; rsp_last_of_run marks the
//   final byte caused by an input transfer.
// Settings port (csr_): index 0 fold_width, index 1 tab_width, always ready; write
//   only while the block is idle.
// Timing: an accepted character is examined in the cycle after the transfer. A
//   character that only joins the line is appended and the block returns to idle. An
//   item that emits bytes sends them one per cycle, popping pending characters from
//   the head of the character row, and pauses while the receiver stalls. req_stall
//   stays high until the item's last byte sits in the output register.
// Reset: synchronous reset empties the pending line and restores fold_width 20
//   and tab_width 8. The character row itself is not cleared.
// Stall: while rsp_stall is high the output register holds its byte and the row
//   does not advance.
module text_line_folder #(
   parameter int BUF_DEPTH = tfl_pkg::BUF_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // input characters
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_ch,
   input  logic                            req_end_of_text,
   // output characters
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_out_char,
   output logic                            rsp_last_of_run,
   // settings
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tfl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tfl_pkg::CSR_DAT_W-1:0]   csr_data
);
   import tfl_pkg::*;

   localparam int IDX_W = $clog2(BUF_DEPTH);
   localparam int CNT_W = $clog2(BUF_DEPTH + 1);
   // columns reach at most BUF_DEPTH * 16 plus one character
   localparam int COL_W = CNT_W + 5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_EMIT,
      ST_NEWLINE
   } state_type;

   // settings
   logic [FOLD_W-1:0] fold_width_ff, fold_width_in;
   logic [TAB_W-1:0]  tab_width_ff, tab_width_in;

   // sequencer and line bookkeeping
   state_type         state_ff, state_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic              eot_ff, eot_in;
   logic [CNT_W-1:0]  count_ff, count_in;     // characters in the row
   logic [CNT_W-1:0]  tabs_ff, tabs_in;       // tabs among them
   logic [CNT_W-1:0]  brk_ff, brk_in;         // fold point, zero when none
   logic [CNT_W-1:0]  brk_tabs_ff, brk_tabs_in;
   logic              prev_blank_ff, prev_blank_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;         // bytes still to pop
   logic              nl_ff, nl_in;           // newline follows the pops
   logic              app_ff, app_in;         // append the character after the newline

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;

   row_ctrl_type      row_ctrl;
   logic [CHAR_W-1:0] head_char;

   logic              out_free;
   logic [COL_W-1:0]  fw, tw, cw, cols, pre;
   logic              over, full, fold, use_brk, ch_blank, ch_tab;
   logic              do_append;

   // ---------------------------------------------------------------
   // settings port
   // ---------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      fold_width_in = fold_width_ff;
      tab_width_in  = tab_width_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_FOLD_WIDTH: fold_width_in = csr_data;
            REG_TAB_WIDTH:  tab_width_in  = csr_data[TAB_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_width_ff <= FOLD_WIDTH_RESET;
         tab_width_ff  <= TAB_WIDTH_RESET;
      end else begin
         fold_width_ff <= fold_width_in;
         tab_width_ff  <= tab_width_in;
      end
   end

   // ---------------------------------------------------------------
   // fold decision, all from registered state
   // ---------------------------------------------------------------
   always_comb begin
      fw = (fold_width_ff == '0) ? COL_W'(1) : COL_W'(fold_width_ff);
      if (tab_width_ff == '0) begin
         tw = COL_W'(1);
      end else if (tab_width_ff > TAB_WIDTH_MAX) begin
         tw = COL_W'(TAB_WIDTH_MAX);
      end else begin
         tw = COL_W'(tab_width_ff);
      end
      ch_tab   = (ch_ff == CH_TAB);
      ch_blank = is_blank(ch_ff);
      cw       = ch_tab ? tw : COL_W'(1);
      // recount columns with the current tab width
      cols     = COL_W'(count_ff - tabs_ff) + COL_W'(tabs_ff) * tw;
      pre      = COL_W'(brk_ff - brk_tabs_ff) + COL_W'(brk_tabs_ff) * tw;
      over     = (cols + cw) > fw;
      full     = count_ff >= CNT_W'(BUF_DEPTH);
      fold     = (count_ff != '0) && (over || full);
      // fold at the break only if the remainder plus this character fits
      use_brk  = (brk_ff != '0) && (brk_ff < count_ff) && ((cols - pre + cw) <= fw);
   end

   // ---------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      eot_in        = eot_ff;
      count_in      = count_ff;
      tabs_in       = tabs_ff;
      brk_in        = brk_ff;
      brk_tabs_in   = brk_tabs_ff;
      prev_blank_in = prev_blank_ff;
      rem_in        = rem_ff;
      nl_in         = nl_ff;
      app_in        = app_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;
      do_append     = 1'b0;
      row_ctrl.shift = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               ch_in    = req_ch;
               eot_in   = req_end_of_text;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (eot_ff || ch_ff == CH_NEWLINE) begin
               // flush the whole line; a newline character adds one
               rem_in        = count_ff;
               nl_in         = !eot_ff;
               app_in        = 1'b0;
               brk_in        = '0;
               prev_blank_in = 1'b0;
               if (count_ff != '0) begin
                  state_in = ST_EMIT;
               end else if (!eot_ff) begin
                  state_in = ST_NEWLINE;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (fold) begin
               rem_in   = use_brk ? brk_ff : count_ff;
               nl_in    = 1'b1;
               app_in   = 1'b1;
               brk_in   = '0;
               state_in = ST_EMIT;
            end else begin
               do_append = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               // pop the head character and advance the row
               row_ctrl.shift = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_char_in    = head_char;
               rsp_last_in    = (rem_ff == CNT_W'(1)) && !nl_ff;
               count_in       = count_ff - CNT_W'(1);
               rem_in         = rem_ff - CNT_W'(1);
               if (head_char == CH_TAB) begin
                  tabs_in = tabs_ff - CNT_W'(1);
               end
               if (rem_ff == CNT_W'(1)) begin
                  state_in = nl_ff ? ST_NEWLINE : ST_IDLE;
               end
            end
         end
         ST_NEWLINE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CH_NEWLINE;
               rsp_last_in  = 1'b1;
               do_append    = app_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // add the character at the tail of the line
      if (do_append) begin
         count_in      = count_in + CNT_W'(1);
         if (ch_tab) begin
            tabs_in = tabs_in + CNT_W'(1);
         end
         if ((count_ff != '0) && ch_blank && !prev_blank_ff) begin
            brk_in      = count_ff;
            brk_tabs_in = tabs_ff;
         end
         prev_blank_in = ch_blank;
      end

      row_ctrl.load      = do_append;
      row_ctrl.load_char = ch_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         tabs_ff       <= '0;
         brk_ff        <= '0;
         brk_tabs_ff   <= '0;
         prev_blank_ff <= 1'b0;
         rem_ff        <= '0;
         nl_ff         <= 1'b0;
         app_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         tabs_ff       <= tabs_in;
         brk_ff        <= brk_in;
         brk_tabs_ff   <= brk_tabs_in;
         prev_blank_ff <= prev_blank_in;
         rem_ff        <= rem_in;
         nl_ff         <= nl_in;
         app_ff        <= app_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      ch_ff       <= ch_in;
      eot_ff      <= eot_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // ---------------------------------------------------------------
   // character row
   // ---------------------------------------------------------------
   tfl_row #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_row (
      .clock     (clock),
      .ctrl      (row_ctrl),
      .load_idx  (count_ff[IDX_W-1:0]),
      .head_char (head_char)
   );

   // ---------------------------------------------------------------
   // ports
   // ---------------------------------------------------------------
   assign req_stall       = reset || (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = rsp_char_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

FILE: rtl/core/tfl_cell.sv
// One character cell of the pending row: loads a new character or takes its neighbor's.
module tfl_cell (
   input  logic                 clock,
   input  tfl_pkg::row_ctrl_type ctrl,
   input  logic                 sel,
   input  logic [7:0]           next_char,
   output logic [7:0]           char_out
);
   import tfl_pkg::*;

   logic [CHAR_W-1:0] char_ff;
   logic [CHAR_W-1:0] char_in;

   always_comb begin
      char_in = char_ff;
      if (ctrl.load && sel) begin
         char_in = ctrl.load_char;
      end else if (ctrl.shift) begin
         char_in = next_char;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

   assign char_out = char_ff;

endmodule

FILE: rtl/core/tfl_row.sv
// Row of character cells; the head cell holds the oldest pending character.
module tfl_row #(
   parameter int BUF_DEPTH = tfl_pkg::BUF_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  tfl_pkg::row_ctrl_type        ctrl,
   input  logic [$clog2(BUF_DEPTH)-1:0] load_idx,
   output logic [7:0]                   head_char
);
   import tfl_pkg::*;

   localparam int IDX_W = $clog2(BUF_DEPTH);

   logic [CHAR_W-1:0] chars [BUF_DEPTH];

   for (genvar i = 0; i < BUF_DEPTH; i++) begin : g_cell
      logic [CHAR_W-1:0] nbr;
      if (i == BUF_DEPTH - 1) begin : g_tail
         assign nbr = CH_NUL;
      end else begin : g_body
         assign nbr = chars[i+1];
      end
      tfl_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .sel       (load_idx == IDX_W'(i)),
         .next_char (nbr),
         .char_out  (chars[i])
      );
   end

   assign head_char = chars[0];

endmodule

FILE: rtl/core/tfl_check.sv
// Port-level checks for the text line folder, bound to the top level.
module tfl_check (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_char,
   input logic       rsp_last_of_run
);

   // an output transfer that is held back stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a held-back byte keeps its value
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_char) && $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   // no new input while the current run still has bytes to come
   a_run_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> req_stall)
      else $error("input taken in the middle of a run");

   // every accepted character is examined before the next one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted on consecutive cycles");

endmodule

bind text_line_folder tfl_check u_tfl_check (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_char    (rsp_out_char),
   .rsp_last_of_run (rsp_last_of_run)
);
